// File: rtl/bri_pkg.sv
// ----------------------------------------------------------------------------
// bri_pkg
// Shared types and constants for the bilinear RGB interpolator.
// ----------------------------------------------------------------------------
package bri_pkg;

  localparam int POS_W     = 20;
  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_LANES = PIX_W / CH_W;

  localparam logic [CH_W-1:0]  CH_MAX      = {CH_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_RESET   = 12'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CASE_INTERP = 2'd0,
    CASE_EDGE   = 2'd1,
    CASE_BLACK  = 2'd2
  } case_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PIX_W-1:0]        top_left_pixel;
    logic [PIX_W-1:0]        top_right_pixel;
    logic [PIX_W-1:0]        bottom_left_pixel;
    logic [PIX_W-1:0]        bottom_right_pixel;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] result_pixel;
    logic [1:0]       case_taken;
  } out_rsp_t;

  typedef struct packed {
    logic  valid;
    case_t kind;
  } pipe_ctl_t;

endpackage

// File: rtl/bri_front.sv
// ----------------------------------------------------------------------------
// bri_front
// First stage: classifies the sample position and splits off the fractions.
// ----------------------------------------------------------------------------
module bri_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  bri_pkg::in_req_t              in_req,
  input  logic [bri_pkg::DIM_W-1:0]     image_width,
  input  logic [bri_pkg::DIM_W-1:0]     image_height,
  output bri_pkg::pipe_ctl_t            s1_ctl_r,
  output bri_pkg::in_req_t              s1_req_r,
  output logic [FRAC_BITS:0]            s1_fx_r,
  output logic [FRAC_BITS:0]            s1_fy_r,
  output logic [FRAC_BITS:0]            s1_gx_r,
  output logic [FRAC_BITS:0]            s1_gy_r
);
  import bri_pkg::*;

  localparam int LIM_W = DIM_W + 1 + FRAC_BITS;
  localparam int CMP_W = (LIM_W > POS_W) ? LIM_W : POS_W;
  localparam int TR_W  = POS_W + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic signed [DIM_W:0]   wm1;
  logic signed [DIM_W:0]   hm1;
  logic signed [CMP_W-1:0] px_e;
  logic signed [CMP_W-1:0] py_e;
  logic signed [CMP_W-1:0] lim_x;
  logic signed [CMP_W-1:0] lim_y;
  logic                    x_neg;
  logic                    y_neg;
  logic [TR_W-1:0]         px_mag;
  logic [TR_W-1:0]         py_mag;
  logic [TR_W-1:0]         tx_mag;
  logic [TR_W-1:0]         ty_mag;
  logic [TR_W-1:0]         tx;
  logic [TR_W-1:0]         ty;
  logic                    in_image;
  logic                    on_edge;
  logic [FRAC_BITS:0]      fx;
  logic [FRAC_BITS:0]      fy;
  pipe_ctl_t               s1_ctl_nxt;

  assign wm1 = $signed({1'b0, image_width}  - {{DIM_W{1'b0}}, 1'b1});
  assign hm1 = $signed({1'b0, image_height} - {{DIM_W{1'b0}}, 1'b1});

  assign px_e  = CMP_W'($signed(in_req.pos_x));
  assign py_e  = CMP_W'($signed(in_req.pos_y));
  assign lim_x = CMP_W'(wm1) <<< FRAC_BITS;
  assign lim_y = CMP_W'(hm1) <<< FRAC_BITS;

  assign x_neg = in_req.pos_x[POS_W-1];
  assign y_neg = in_req.pos_y[POS_W-1];

  assign in_image = !x_neg && !y_neg && (px_e < lim_x) && (py_e < lim_y);

  // truncation toward zero
  assign px_mag = x_neg ? (TR_W'(0) - TR_W'($signed(in_req.pos_x)))
                        : TR_W'($signed(in_req.pos_x));
  assign py_mag = y_neg ? (TR_W'(0) - TR_W'($signed(in_req.pos_y)))
                        : TR_W'($signed(in_req.pos_y));
  assign tx_mag = px_mag >> FRAC_BITS;
  assign ty_mag = py_mag >> FRAC_BITS;
  assign tx     = x_neg ? (TR_W'(0) - tx_mag) : tx_mag;
  assign ty     = y_neg ? (TR_W'(0) - ty_mag) : ty_mag;

  assign on_edge = (tx == TR_W'(wm1)) || (ty == TR_W'(hm1));

  assign fx = {1'b0, in_req.pos_x[FRAC_BITS-1:0]};
  assign fy = {1'b0, in_req.pos_y[FRAC_BITS-1:0]};

  always_comb begin
    s1_ctl_nxt.valid = in_valid;
    if (in_image) begin
      s1_ctl_nxt.kind = CASE_INTERP;
    end else if (on_edge) begin
      s1_ctl_nxt.kind = CASE_EDGE;
    end else begin
      s1_ctl_nxt.kind = CASE_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '{valid: 1'b0, kind: CASE_BLACK};
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r <= in_req;
    s1_fx_r  <= fx;
    s1_fy_r  <= fy;
    s1_gx_r  <= ONE - fx;
    s1_gy_r  <= ONE - fy;
  end

endmodule

// File: rtl/bri_weight.sv
// ----------------------------------------------------------------------------
// bri_weight
// Second stage: the four bilinear weights, 2*FRAC_BITS fraction bits each.
// ----------------------------------------------------------------------------
module bri_weight #(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic [FRAC_BITS:0]     fx,
  input  logic [FRAC_BITS:0]     fy,
  input  logic [FRAC_BITS:0]     gx,
  input  logic [FRAC_BITS:0]     gy,
  output logic [2*FRAC_BITS:0]   w00_r,
  output logic [2*FRAC_BITS:0]   w01_r,
  output logic [2*FRAC_BITS:0]   w10_r,
  output logic [2*FRAC_BITS:0]   w11_r
);

  localparam int W_W    = 2 * FRAC_BITS + 1;
  localparam int FULL_W = 2 * FRAC_BITS + 2;

  logic [FULL_W-1:0] w00_nxt;
  logic [FULL_W-1:0] w01_nxt;
  logic [FULL_W-1:0] w10_nxt;
  logic [FULL_W-1:0] w11_nxt;

  assign w00_nxt = gy * gx;
  assign w01_nxt = gy * fx;
  assign w10_nxt = fy * gx;
  assign w11_nxt = fy * fx;

  // each weight is at most 2^(2*FRAC_BITS)
  always_ff @(posedge clk) begin
    w00_r <= w00_nxt[W_W-1:0];
    w01_r <= w01_nxt[W_W-1:0];
    w10_r <= w10_nxt[W_W-1:0];
    w11_r <= w11_nxt[W_W-1:0];
  end

endmodule

// File: rtl/bri_lane.sv
// ----------------------------------------------------------------------------
// bri_lane
// One color channel: weighted products, round half to even, clamp, sum.
// ----------------------------------------------------------------------------
module bri_lane #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic [2*FRAC_BITS:0]          w00,
  input  logic [2*FRAC_BITS:0]          w01,
  input  logic [2*FRAC_BITS:0]          w10,
  input  logic [2*FRAC_BITS:0]          w11,
  input  logic [bri_pkg::CH_W-1:0]      v00,
  input  logic [bri_pkg::CH_W-1:0]      v01,
  input  logic [bri_pkg::CH_W-1:0]      v10,
  input  logic [bri_pkg::CH_W-1:0]      v11,
  output logic [bri_pkg::CH_W-1:0]      chan_sum
);
  import bri_pkg::*;

  localparam int S_W   = 2 * FRAC_BITS;
  localparam int P_W   = S_W + 1 + CH_W;
  localparam int Q_W   = P_W - S_W;
  localparam int SUM_W = CH_W + 2;
  localparam logic [S_W-1:0] HALF = {1'b1, {(S_W-1){1'b0}}};

  logic [P_W-1:0]   prod_r [4];
  logic [CH_W-1:0]  term_r [4];
  logic [P_W-1:0]   prod_nxt [4];
  logic [CH_W-1:0]  term_nxt [4];
  logic [SUM_W-1:0] sum;

  function automatic logic [CH_W-1:0] round_clamp(input logic [P_W-1:0] p);
    logic [Q_W-1:0] q;
    logic [S_W-1:0] r;
    logic [Q_W:0]   qr;
    logic           up;
    q  = p[P_W-1:S_W];
    r  = p[S_W-1:0];
    up = (r > HALF) || ((r == HALF) && q[0]);
    qr = {1'b0, q} + (Q_W + 1)'(up);
    return (qr > (Q_W + 1)'(CH_MAX)) ? CH_MAX : qr[CH_W-1:0];
  endfunction

  assign prod_nxt[0] = P_W'(w00) * P_W'(v00);
  assign prod_nxt[1] = P_W'(w01) * P_W'(v01);
  assign prod_nxt[2] = P_W'(w10) * P_W'(v10);
  assign prod_nxt[3] = P_W'(w11) * P_W'(v11);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term_nxt[i] = round_clamp(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= prod_nxt[i];
      term_r[i] <= term_nxt[i];
    end
  end

  assign sum = SUM_W'(term_r[0]) + SUM_W'(term_r[1])
             + SUM_W'(term_r[2]) + SUM_W'(term_r[3]);

  assign chan_sum = (sum > SUM_W'(CH_MAX)) ? CH_MAX : sum[CH_W-1:0];

endmodule

// File: rtl/bilinear_rgb_interpolator.sv
// An accepted start passes through s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r and out_valid_r to the out_valid strobe.
// Throughput: one request per cycle while busy is low; busy is high only while rst_n is low
// and until a clock edge with rst_n high clears busy_r, then stays low.
// Results cannot be stalled: each appears for one cycle on out_valid.
// Reset clears the pipeline valid bits and sets the image size to 1024x1024.
// ----------------------------------------------------------------------------
// bilinear_rgb_interpolator
// Five-stage pipelined bilinear sampler for 8-bit-per-channel pixels.
// ----------------------------------------------------------------------------
module bilinear_rgb_interpolator #(
  parameter int FRAC_BITS = 8,
  parameter int CHANNELS  = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  bri_pkg::in_req_t                  in_req,
  output logic                              out_valid,
  output bri_pkg::out_rsp_t                 out_rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bri_pkg::DIM_W-1:0]         cfg_data
);
  import bri_pkg::*;

  localparam int LANES = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

  logic               busy_r;
  logic [DIM_W-1:0]   image_width_r;
  logic [DIM_W-1:0]   image_height_r;

  pipe_ctl_t          s1_ctl;
  in_req_t            s1_req;
  logic [FRAC_BITS:0] s1_fx;
  logic [FRAC_BITS:0] s1_fy;
  logic [FRAC_BITS:0] s1_gx;
  logic [FRAC_BITS:0] s1_gy;

  pipe_ctl_t          s2_ctl_r;
  in_req_t            s2_req_r;
  logic [2*FRAC_BITS:0] w00;
  logic [2*FRAC_BITS:0] w01;
  logic [2*FRAC_BITS:0] w10;
  logic [2*FRAC_BITS:0] w11;

  pipe_ctl_t          s3_ctl_r;
  logic [PIX_W-1:0]   s3_tl_r;
  pipe_ctl_t          s4_ctl_r;
  logic [PIX_W-1:0]   s4_tl_r;

  logic [CH_W-1:0]    lane_sum [LANES];
  logic [PIX_W-1:0]   interp_pix;

  logic               out_valid_r;
  out_rsp_t           out_rsp_r;
  out_rsp_t           out_rsp_nxt;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_RESET;
      image_height_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bri_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start && !busy_r),
    .in_req       (in_req),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .s1_ctl_r     (s1_ctl),
    .s1_req_r     (s1_req),
    .s1_fx_r      (s1_fx),
    .s1_fy_r      (s1_fy),
    .s1_gx_r      (s1_gx),
    .s1_gy_r      (s1_gy)
  );

  bri_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
    .clk   (clk),
    .fx    (s1_fx),
    .fy    (s1_fy),
    .gx    (s1_gx),
    .gy    (s1_gy),
    .w00_r (w00),
    .w01_r (w01),
    .w10_r (w10),
    .w11_r (w11)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bri_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk      (clk),
      .w00      (w00),
      .w01      (w01),
      .w10      (w10),
      .w11      (w11),
      .v00      (s2_req_r.top_left_pixel[l*CH_W +: CH_W]),
      .v01      (s2_req_r.top_right_pixel[l*CH_W +: CH_W]),
      .v10      (s2_req_r.bottom_left_pixel[l*CH_W +: CH_W]),
      .v11      (s2_req_r.bottom_right_pixel[l*CH_W +: CH_W]),
      .chan_sum (lane_sum[l])
    );
  end

  always_comb begin
    interp_pix = '0;
    for (int l = 0; l < LANES; l++) begin
      interp_pix[l*CH_W +: CH_W] = lane_sum[l];
    end
  end

  always_comb begin
    out_rsp_nxt.case_taken = s4_ctl_r.kind;
    case (s4_ctl_r.kind)
      CASE_INTERP: out_rsp_nxt.result_pixel = interp_pix;
      CASE_EDGE:   out_rsp_nxt.result_pixel = s4_tl_r;
      default:     out_rsp_nxt.result_pixel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r    <= '{valid: 1'b0, kind: CASE_BLACK};
      s3_ctl_r    <= '{valid: 1'b0, kind: CASE_BLACK};
      s4_ctl_r    <= '{valid: 1'b0, kind: CASE_BLACK};
      out_valid_r <= 1'b0;
    end else begin
      s2_ctl_r    <= s1_ctl;
      s3_ctl_r    <= s2_ctl_r;
      s4_ctl_r    <= s3_ctl_r;
      out_valid_r <= s4_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_req_r  <= s1_req;
    s3_tl_r   <= s2_req_r.top_left_pixel;
    s4_tl_r   <= s3_tl_r;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

// File: rtl/bri_checker.sv
// ----------------------------------------------------------------------------
// bri_checker
// Port-level checks on the bilinear RGB interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module bri_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input bri_pkg::in_req_t              in_req,
  input logic                          out_valid,
  input bri_pkg::out_rsp_t             out_rsp
);
  import bri_pkg::*;

  logic accepted;
  assign accepted = start && !busy;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |-> ##5 out_valid)
    else $error("accepted request gave no result after 5 cycles");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accepted, 5))
    else $error("result without a matching request");

  a_case_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.case_taken == CASE_INTERP ||
                   out_rsp.case_taken == CASE_EDGE ||
                   out_rsp.case_taken == CASE_BLACK))
    else $error("case_taken out of range");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.case_taken == CASE_BLACK) |-> out_rsp.result_pixel == '0)
    else $error("outside sample not black");

  a_edge_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.case_taken == CASE_EDGE)
      |-> out_rsp.result_pixel == $past(in_req.top_left_pixel, 5))
    else $error("edge sample is not the top-left pixel");

endmodule

bind bilinear_rgb_interpolator bri_checker u_bri_checker (.*);
